// ===== design/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
// SFIR_ASSERT checks a property while reset is released.
// SFIR_ASSERT_RST checks a property at every edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SFIR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("filter assertion failed");
`define SFIR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("filter reset assertion failed");
`else
`define SFIR_ASSERT(lbl, clk, rst_n, prop)
`define SFIR_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== design/sfir_pkg.sv =====
`default_nettype none

package sfir_pkg;

    // Fixed arithmetic widths of the datapath.
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PAIR_W    = SAMPLE_W + 1;
    localparam int PROD_W    = PAIR_W + COEF_W;
    localparam int NUM_COEFS = 8;
    localparam int COEF_IDX_W = 3;
    // Up to eight products are summed, so three guard bits suffice.
    localparam int ACC_W     = PROD_W + COEF_IDX_W;
    localparam int FRAC_W    = 15;
    localparam int SUM_W     = ACC_W + 1;
    localparam int SH_W      = SUM_W - FRAC_W;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SH_W-1:0]  SAT_MAX    = SH_W'(32767);
    localparam logic signed [SH_W-1:0]  SAT_MIN    = -SH_W'(32768);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    // Round half up, drop the fraction bits and saturate to a sample.
    function automatic t_sample round_sat(input t_acc acc);
        logic signed [SUM_W-1:0] sum;
        logic signed [SH_W-1:0]  sh;
        t_sample                 res;
        sum = $signed({acc[ACC_W-1], acc}) + ROUND_HALF;
        sh  = sum[SUM_W-1:FRAC_W];
        if (sh > SAT_MAX) begin
            res = SAMPLE_W'(SAT_MAX);
        end else if (sh < SAT_MIN) begin
            res = SAMPLE_W'(SAT_MIN);
        end else begin
            res = sh[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/sfir_tap_cell.sv =====
`default_nettype none

module sfir_tap_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_shift,
    input  sfir_pkg::t_sample i_d,
    output sfir_pkg::t_sample o_q
);
    import sfir_pkg::*;

    t_sample r_q;
    t_sample n_q;

    // The cell takes its neighbour's sample whenever a new request enters the line.
    always_comb begin
        n_q = i_shift ? i_d : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== design/sfir_mac_cell.sv =====
`default_nettype none

module sfir_mac_cell (
    input  wire               i_clk,
    input  sfir_pkg::t_sample i_near,
    input  sfir_pkg::t_sample i_far,
    input  sfir_pkg::t_coef   i_coef,
    input  sfir_pkg::t_acc    i_acc,
    output sfir_pkg::t_acc    o_acc
);
    import sfir_pkg::*;

    logic signed [PAIR_W-1:0] r_pair;
    logic signed [PROD_W-1:0] r_prod;
    t_acc                     r_acc;
    logic signed [PAIR_W-1:0] n_pair;
    logic signed [PROD_W-1:0] n_prod;
    t_acc                     n_acc;

    // Pre-add the symmetric pair, multiply by the coefficient, then add the
    // partial sum handed on by the previous cell.
    always_comb begin
        n_pair = $signed({i_near[SAMPLE_W-1], i_near}) + $signed({i_far[SAMPLE_W-1], i_far});
        n_prod = r_pair * i_coef;
        n_acc  = i_acc + $signed({{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod});
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== design/symmetric_fir_lowpass_top.sv =====
// Symmetric FIR low-pass filter. Each accepted request shifts one sample into
// a TAPS-long delay line; the result appears on the output channel once the
// sum has passed the pair cells into the output register, and the input is
// released on the edge that loads the result, so the next request is taken
// in the next cycle: the block takes no new sample until the result of the
// last one is loaded. The processing time is set by the chain of pair
// cells: the partial sum moves one cell per cycle after a pre-add and a
// multiply stage. The input channel accepts while an earlier result still
// waits in the output register; a finished sum waits for that register to
// drain, and the input stays stalled for as long as it waits.
// Coefficients coef_0 to coef_7 (Q1.15) sit at byte addresses 0 to 28 and are
// to be written only while the filter is idle; the block itself does not enforce this.

`default_nettype none
`include "assert_macros.svh"

module symmetric_fir_lowpass_top #(
    parameter int TAPS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  sfir_pkg::t_sample           i_sample_in,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output sfir_pkg::t_sample           o_sample_out,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [sfir_pkg::APB_AW-1:0]  paddr,
    input  wire [sfir_pkg::APB_DW-1:0]  pwdata,
    output logic [sfir_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import sfir_pkg::*;

    localparam int NPAIR = (TAPS + 1) / 2;
    localparam int LAT   = NPAIR + 3;
    localparam int CNT_W = $clog2(LAT);

    t_coef             r_coef [NUM_COEFS];
    t_sample           w_tap  [TAPS];
    t_acc              w_acc  [NPAIR+1];
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_out_valid;
    logic              n_out_valid;
    t_sample           r_sample_out;
    t_sample           n_sample_out;
    logic              w_in_acc;
    logic              w_load;
    logic              w_cfg_wr;
    logic [COEF_IDX_W-1:0] w_cfg_idx;

    // Configuration port.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[APB_AW-1:2];
    assign prdata    = {{(APB_DW-COEF_W){r_coef[w_cfg_idx][COEF_W-1]}}, r_coef[w_cfg_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (w_cfg_wr) begin
            r_coef[w_cfg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    // Delay line: the newest sample sits in the first cell.
    assign w_in_acc = i_in_valid && !o_in_stall;

    generate
        for (genvar k = 0; k < TAPS; k++) begin : g_tap
            if (k == 0) begin : g_head
                sfir_tap_cell u_tap (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_in_acc),
                    .i_d     (i_sample_in),
                    .o_q     (w_tap[k])
                );
            end else begin : g_body
                sfir_tap_cell u_tap (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_in_acc),
                    .i_d     (w_tap[k-1]),
                    .o_q     (w_tap[k])
                );
            end
        end
    endgenerate

    // Chain of pair cells; the centre cell of an odd line has no partner.
    assign w_acc[0] = '0;

    generate
        for (genvar k = 0; k < NPAIR; k++) begin : g_mac
            if (2 * k + 1 == TAPS) begin : g_centre
                sfir_mac_cell u_mac (
                    .i_clk  (i_clk),
                    .i_near (w_tap[k]),
                    .i_far  ('0),
                    .i_coef (r_coef[k]),
                    .i_acc  (w_acc[k]),
                    .o_acc  (w_acc[k+1])
                );
            end else begin : g_pair
                sfir_mac_cell u_mac (
                    .i_clk  (i_clk),
                    .i_near (w_tap[k]),
                    .i_far  (w_tap[TAPS-1-k]),
                    .i_coef (r_coef[k]),
                    .i_acc  (w_acc[k]),
                    .o_acc  (w_acc[k+1])
                );
            end
        end
    endgenerate

    // Control outputs: stall while a sum is in flight, load when it is complete and the output register is free.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_load     = (r_state == ST_BUSY) && (r_cnt == '0) &&
                     (!r_out_valid || !i_out_stall);
    end

    // Next state and cycle counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_BUSY;
                    n_cnt   = CNT_W'(LAT - 1);
                end
            end
            ST_BUSY: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end else if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_sample_out = r_sample_out;
        if (w_load) begin
            n_out_valid  = 1'b1;
            n_sample_out = round_sat(w_acc[NPAIR]);
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample_out <= n_sample_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    // Assertions.
    `SFIR_ASSERT(a_accept_starts, i_clk, i_rst_n, w_in_acc |=> (r_state == ST_BUSY))
    `SFIR_ASSERT(a_busy_stalls, i_clk, i_rst_n, (r_state == ST_BUSY) |-> o_in_stall)
    `SFIR_ASSERT(a_result_timed, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ST_BUSY && r_cnt == '0))
    `SFIR_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && r_state == ST_IDLE))

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfir_pkg::*;

    localparam int     TAPS            = 16;
    localparam int     LINE_MASK       = TAPS - 1;
    localparam int     CLK_HALF        = 5;
    localparam int     RESET_CYCLES    = 12;
    localparam int     REG_STRIDE      = 4;
    localparam int     OUTER_PAIR      = 0;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     REPORT_LIMIT    = 10;
    localparam longint CYCLE_LIMIT     = 400_000;

    localparam t_sample SAMPLE_HI = 16'sh7FFF;
    localparam t_sample SAMPLE_LO = 16'sh8000;
    localparam t_coef   COEF_HI   = 16'sh7FFF;
    localparam t_coef   COEF_LO   = 16'sh8000;

    // Tracks the delay line and coefficients, and holds the filtered samples
    // still owed by the block, oldest first.
    class fir_scoreboard;
        t_coef       coefs [NUM_COEFS];
        t_sample     history [TAPS];
        int          write_slot;
        t_sample     expected_outputs [$];
        int unsigned mismatches;

        function new();
            foreach (coefs[i]) coefs[i] = '0;
            foreach (history[i]) history[i] = '0;
            write_slot = 0;
            mismatches = 0;
        endfunction

        // Symmetric sum with the newest sample in slot; round half up,
        // floor-shift by 15 and saturate.
        function t_sample filtered_value(int slot);
            longint  acc;
            longint  pair;
            t_sample res;
            acc = 0;
            for (int i = 0; i < TAPS / 2; i++) begin
                pair = longint'(history[(slot - i) & LINE_MASK])
                     + longint'(history[(slot - (TAPS - 1 - i)) & LINE_MASK]);
                acc += longint'(coefs[i]) * pair;
            end
            acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
            if (acc > longint'(SAMPLE_HI)) begin
                res = SAMPLE_HI;
            end else if (acc < longint'(SAMPLE_LO)) begin
                res = SAMPLE_LO;
            end else begin
                res = t_sample'(acc);
            end
            return res;
        endfunction

        function void take_sample(t_sample value);
            history[write_slot] = value;
            expected_outputs.push_back(filtered_value(write_slot));
            write_slot = (write_slot + 1) & LINE_MASK;
        endfunction

        function void compare_output(t_sample got);
            t_sample want;
            if (expected_outputs.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("sample_out %0d arrived with nothing outstanding", got);
                end
                mismatches++;
            end else begin
                want = expected_outputs.pop_front();
                if (got !== want) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("sample_out mismatch: expected %0d, got %0d", want, got);
                    end
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_sample             i_sample_in = '0;
    logic                i_out_stall = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [APB_DW-1:0]   pwdata      = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t_sample             o_sample_out;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    fir_scoreboard       filter_check = new();
    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct     = 0;
    int unsigned         hold_off_left = 0;
    longint unsigned     cycle_count   = 0;

    symmetric_fir_lowpass_top #(
        .TAPS(TAPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample_out(o_sample_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Output side: a long hold-off when one is pending, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall = 1'b1;
            hold_off_left--;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog, and the check of every result taken from the block.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** symmetric_fir_lowpass_top: FAILED **");
            $finish;
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            filter_check.compare_output(o_sample_out);
        end
    end

    function automatic t_sample pick_sample();
        t_sample s;
        case ($urandom_range(9))
            0:       s = SAMPLE_HI;
            1:       s = SAMPLE_LO;
            2, 3:    s = t_sample'(int'($urandom_range(512)) - 256);
            default: s = t_sample'($urandom);
        endcase
        return s;
    endfunction

    // Offers one sample request, with random idle cycles ahead of it, and
    // holds it steady until the block takes it.
    task automatic push_sample(input t_sample value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_sample_in = value;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        filter_check.take_sample(value);
    endtask

    // Stops offering and waits for every outstanding result, then lets the
    // pipeline settle.
    task automatic wait_for_outputs();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (filter_check.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access cycle of a register write.
    task automatic write_coef(input int idx, input t_coef value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(idx * REG_STRIDE);
        pwdata  = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        filter_check.coefs[idx] = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_all_coefs(input t_coef value);
        for (int i = 0; i < NUM_COEFS; i++) begin
            write_coef(i, value);
        end
    endtask

    // Binary weights make exact halfway sums, and so rounding ties, common.
    task automatic load_random_coefs(input bit binary_weights);
        t_coef c;
        for (int i = 0; i < NUM_COEFS; i++) begin
            if (binary_weights) begin
                c = t_coef'(1 << $urandom_range(14, 10));
                if ($urandom_range(1) == 1) begin
                    c = -c;
                end
                if ($urandom_range(3) == 0) begin
                    c = '0;
                end
            end else begin
                case ($urandom_range(7))
                    0:       c = COEF_HI;
                    1:       c = COEF_LO;
                    default: c = t_coef'($urandom) >>> $urandom_range(5);
                endcase
            end
            write_coef(i, c);
        end
    endtask

    task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count) push_sample(pick_sample());
        wait_for_outputs();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(posedge i_clk);

        // Start-up: an impulse into the cleared delay line, distinct weights.
        for (int i = 0; i < NUM_COEFS; i++) begin
            write_coef(i, t_coef'((i % 2 == 0) ? 4096 * (i + 1) : -4096 * (i + 1)));
        end
        push_sample(SAMPLE_HI);
        repeat (3) push_sample('0);
        wait_for_outputs();

        // Full-scale weights drive the output into both saturation limits.
        write_all_coefs(COEF_HI);
        repeat (4) push_sample(SAMPLE_HI);
        repeat (4) push_sample(SAMPLE_LO);
        wait_for_outputs();
        write_all_coefs(COEF_LO);
        repeat (2) push_sample(SAMPLE_HI);
        repeat (2) push_sample(SAMPLE_LO);
        wait_for_outputs();

        // Half weight on the outer pair: odd pair sums fall exactly halfway.
        write_all_coefs('0);
        write_coef(OUTER_PAIR, t_coef'(16384));
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd3);
        push_sample(-16'sd3);
        push_sample('0);
        wait_for_outputs();

        // Random samples under the different idling patterns.
        load_random_coefs(1'b0);
        run_phase(220, 0, 0);
        load_random_coefs(1'b0);
        run_phase(220, 74, 0);
        load_random_coefs(1'b1);
        run_phase(220, 0, 74);
        load_random_coefs(1'b0);
        run_phase(220, 13, 13);

        // The output side holds off while requests keep coming, so the
        // block fills up and stalls its input.
        load_random_coefs(1'b0);
        hold_off_left = HOLD_OFF_CYCLES;
        run_phase(150, 0, 0);

        load_random_coefs(1'b1);
        run_phase(250, 0, 0);

        if (filter_check.mismatches == 0 && filter_check.pending() == 0) begin
            $display("** symmetric_fir_lowpass_top: PASSED **");
        end else begin
            $display("** symmetric_fir_lowpass_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== symmetric_fir_lowpass_top.f =====
+incdir+design
design/sfir_pkg.sv
design/sfir_tap_cell.sv
design/sfir_mac_cell.sv
design/symmetric_fir_lowpass_top.sv
bench/testbench.sv
